>>> rtl/dark_channel_window_filter_unit_macros.svh
// Assertion macros for the dark channel window filter.
// Each macro expects signals clk and rst_n in the scope where it is used.
`ifndef DARK_CHANNEL_WINDOW_FILTER_UNIT_MACROS_SVH
`define DARK_CHANNEL_WINDOW_FILTER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DCWF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DCWF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dcwf_pkg.sv
// Shared constants, types and register codes for the dark channel window filter.
// No dependencies; every other file but the macro header refers to it by scoped names.
`default_nettype none
package dcwf_pkg;
  localparam int MaxWidth  = 1024;
  localparam int MaxRadius = 7;
  localparam int MaxHeight = 4096;
  localparam int RingRows  = 2 * MaxRadius + 1;
  localparam int Depth     = RingRows * MaxWidth;
  localparam int ColW      = $clog2(MaxWidth);
  localparam int RingW     = $clog2(RingRows);
  localparam int AddrW     = $clog2(Depth);

  typedef logic [7:0]       pix_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_RADIUS = 3'd2,
    CFG_MODE   = 3'd3
  } cfg_idx_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    pix_t  wdata;
    logic  re;
    addr_t raddr;
  } ram_req_t;
endpackage
`default_nettype wire

>>> rtl/dcwf_if.sv
// Channel interfaces of the dark channel window filter: pixel input, result
// output and configuration write. Depends on dcwf_pkg.
`default_nettype none
interface dcwf_in_if;
  logic valid;
  logic ready;
  logic command;
  dcwf_pkg::pix_t pixel_blue;
  dcwf_pkg::pix_t pixel_green;
  dcwf_pkg::pix_t pixel_red;
  modport source (output valid, command, pixel_blue, pixel_green, pixel_red, input ready);
  modport sink (input valid, command, pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface dcwf_out_if;
  logic valid;
  logic ready;
  dcwf_pkg::pix_t filtered_value;
  logic last_of_frame;
  modport source (output valid, filtered_value, last_of_frame, input ready);
  modport sink (input valid, filtered_value, last_of_frame, output ready);
endinterface

interface dcwf_cfg_if;
  logic valid;
  logic ready;
  logic [2:0] index;
  logic [12:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/dcwf_line_ram.sv
// Line store: ring of channel-minimum rows, one write and one registered read
// port. Depends on dcwf_pkg.
`default_nettype none
module dcwf_line_ram (
  input  wire logic              clk,
  input  wire dcwf_pkg::ram_req_t req,
  output dcwf_pkg::pix_t         rdata
);
  dcwf_pkg::pix_t mem [dcwf_pkg::Depth];
  dcwf_pkg::pix_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

>>> rtl/dcwf_window_ctrl.sv
// Sequencer of the filter: configuration, frame counters, line store writes,
// the window read sweep and the result register. Depends on dcwf_pkg,
// dcwf_if and the assertion macros.
`default_nettype none
`include "dark_channel_window_filter_unit_macros.svh"
module dcwf_window_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  dcwf_in_if.sink                 in_ch,
  dcwf_out_if.source              out_ch,
  dcwf_cfg_if.sink                cfg_ch,
  output dcwf_pkg::ram_req_t      ram_req,
  input  wire dcwf_pkg::pix_t     ram_rdata
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_STEP = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_TAIL = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  localparam int CntW = 23;

  state_t state_r, state_nxt;

  logic [10:0] width_r;
  logic [12:0] height_r;
  logic [2:0]  radius_r;
  logic        mode_r;

  logic [10:0]     w_c, w_eff_r;
  logic [12:0]     h_c, h_eff_r;
  logic [2:0]      r_c, r_eff_r;
  logic [CntW-1:0] total_c, total_r;
  logic [13:0]     delay_c, delay_r;

  logic                      cmd_r, cmd_nxt;
  dcwf_pkg::pix_t            pix_r, pix_nxt, min_rg;
  logic [dcwf_pkg::ColW-1:0]  col_r, col_nxt, ocol_r, ocol_nxt;
  logic [dcwf_pkg::RingW-1:0] ring_r, ring_nxt, oring_r, oring_nxt;
  logic [11:0]               orow_r, orow_nxt;
  logic [CntW-1:0]           items_r, items_nxt, results_r, results_nxt, items_inc;
  logic [3:0]                dx_r, dx_nxt, dy_r, dy_nxt, span;
  logic                      rd_valid_r;
  dcwf_pkg::pix_t            best_r, best_nxt;
  logic                      out_valid_r, out_valid_nxt, out_last_r, out_last_nxt;
  dcwf_pkg::pix_t            out_val_r, out_val_nxt;

  logic signed [12:0] sx, wm1;
  logic signed [14:0] sy, hm1;
  logic signed [6:0]  ring_sum;
  logic [dcwf_pkg::ColW-1:0]  rd_x;
  logic [dcwf_pkg::RingW-1:0] rd_ring;
  logic cfg_hit, restart;

  // Effective geometry, clamped from the configuration registers and registered.
  always_comb begin
    w_c = width_r;
    if (width_r < 11'd2) w_c = 11'd2;
    if (width_r > 11'(dcwf_pkg::MaxWidth)) w_c = 11'(dcwf_pkg::MaxWidth);
    h_c = height_r;
    if (height_r < 13'd2) h_c = 13'd2;
    if (height_r > 13'(dcwf_pkg::MaxHeight)) h_c = 13'(dcwf_pkg::MaxHeight);
    r_c = radius_r;
    if ({1'b0, radius_r} > 4'(dcwf_pkg::MaxRadius)) r_c = 3'(dcwf_pkg::MaxRadius);
    if (11'(r_c) > w_c - 11'd1) r_c = 3'(w_c - 11'd1);
    if (13'(r_c) > h_c - 13'd1) r_c = 3'(h_c - 13'd1);
    total_c = CntW'(w_c) * CntW'(h_c);
    delay_c = 14'(r_c) * 14'(w_c) + 14'(r_c);
  end

  always_ff @(posedge clk) begin
    w_eff_r <= w_c;
    h_eff_r <= h_c;
    r_eff_r <= r_c;
    total_r <= total_c;
    delay_r <= delay_c;
  end

  assign cfg_ch.ready = 1'b1;
  assign cfg_hit = cfg_ch.valid && (cfg_ch.index == dcwf_pkg::CFG_WIDTH ||
                   cfg_ch.index == dcwf_pkg::CFG_HEIGHT ||
                   cfg_ch.index == dcwf_pkg::CFG_RADIUS ||
                   cfg_ch.index == dcwf_pkg::CFG_MODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'(dcwf_pkg::MaxWidth);
      height_r <= 13'd768;
      radius_r <= 3'd1;
      mode_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dcwf_pkg::CFG_WIDTH:  width_r  <= cfg_ch.data[10:0];
        dcwf_pkg::CFG_HEIGHT: height_r <= cfg_ch.data;
        dcwf_pkg::CFG_RADIUS: radius_r <= cfg_ch.data[2:0];
        dcwf_pkg::CFG_MODE:   mode_r   <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  // Mirrored window addresses for the current sweep position.
  assign span = {r_eff_r, 1'b0};
  always_comb begin
    wm1 = $signed({2'b0, w_eff_r}) - 13'sd1;
    sx  = $signed({3'b0, ocol_r}) + $signed({9'b0, dx_r}) - $signed({10'b0, r_eff_r});
    if (sx < 0) sx = -sx;
    if (sx > wm1) sx = (wm1 <<< 1) - sx;
    if (sx < 0) sx = '0;
    rd_x = sx[dcwf_pkg::ColW-1:0];
    hm1 = $signed({2'b0, h_eff_r}) - 15'sd1;
    sy  = $signed({3'b0, orow_r}) + $signed({11'b0, dy_r}) - $signed({12'b0, r_eff_r});
    if (sy < 0) sy = -sy;
    if (sy > hm1) sy = (hm1 <<< 1) - sy;
    if (sy < 0) sy = '0;
    // The mirrored row lies within twice the radius of the output row.
    ring_sum = $signed({3'b0, oring_r}) + 7'(sy - $signed({3'b0, orow_r}));
    if (ring_sum < 0) ring_sum = ring_sum + 7'(dcwf_pkg::RingRows);
    else if (ring_sum >= 7'(dcwf_pkg::RingRows)) ring_sum = ring_sum - 7'(dcwf_pkg::RingRows);
    rd_ring = ring_sum[dcwf_pkg::RingW-1:0];
  end

  assign min_rg    = (in_ch.pixel_red < in_ch.pixel_green) ? in_ch.pixel_red : in_ch.pixel_green;
  assign items_inc = items_r + CntW'(1);
  assign in_ch.ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pix_nxt       = pix_r;
    col_nxt       = col_r;
    ring_nxt      = ring_r;
    ocol_nxt      = ocol_r;
    orow_nxt      = orow_r;
    oring_nxt     = oring_r;
    items_nxt     = items_r;
    results_nxt   = results_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    restart       = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.waddr = dcwf_pkg::AddrW'(int'(ring_r) * dcwf_pkg::MaxWidth + int'(col_r));
    ram_req.wdata = pix_r;
    ram_req.re    = 1'b0;
    ram_req.raddr = dcwf_pkg::AddrW'(int'(rd_ring) * dcwf_pkg::MaxWidth + int'(rd_x));

    if (rd_valid_r) begin
      if (mode_r ? (ram_rdata > best_r) : (ram_rdata < best_r)) best_nxt = ram_rdata;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          pix_nxt   = (in_ch.pixel_blue < min_rg) ? in_ch.pixel_blue : min_rg;
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = ST_IDLE;
        if (!(items_r < total_r && cmd_r)) begin
          if (items_r < total_r) begin
            ram_req.we = 1'b1;
            if ({1'b0, col_r} + 11'd1 == w_eff_r) begin
              col_nxt  = '0;
              ring_nxt = (ring_r == dcwf_pkg::RingW'(dcwf_pkg::RingRows - 1)) ? '0
                         : ring_r + dcwf_pkg::RingW'(1);
            end else begin
              col_nxt = col_r + dcwf_pkg::ColW'(1);
            end
          end
          items_nxt = items_inc;
          if (items_inc - results_r > CntW'(delay_r) && results_r < total_r) begin
            state_nxt = ST_SCAN;
            dx_nxt    = '0;
            dy_nxt    = '0;
            best_nxt  = mode_r ? 8'd0 : 8'hFF;
          end
        end
      end
      ST_SCAN: begin
        ram_req.re = 1'b1;
        if (dx_r == span) begin
          dx_nxt = '0;
          if (dy_r == span) state_nxt = ST_TAIL;
          else dy_nxt = dy_r + 4'd1;
        end else begin
          dx_nxt = dx_r + 4'd1;
        end
      end
      ST_TAIL: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = best_r;
          out_last_nxt  = (results_r + CntW'(1) == total_r);
          results_nxt   = results_r + CntW'(1);
          state_nxt     = ST_IDLE;
          if ({1'b0, ocol_r} + 11'd1 == w_eff_r) begin
            ocol_nxt  = '0;
            orow_nxt  = orow_r + 12'd1;
            oring_nxt = (oring_r == dcwf_pkg::RingW'(dcwf_pkg::RingRows - 1)) ? '0
                        : oring_r + dcwf_pkg::RingW'(1);
          end else begin
            ocol_nxt = ocol_r + dcwf_pkg::ColW'(1);
          end
          if (results_r + CntW'(1) == total_r) restart = 1'b1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (restart || cfg_hit) begin
      col_nxt     = '0;
      ring_nxt    = '0;
      ocol_nxt    = '0;
      orow_nxt    = '0;
      oring_nxt   = '0;
      items_nxt   = '0;
      results_nxt = '0;
    end
    if (cfg_hit) state_nxt = ST_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_r       <= '0;
      ring_r      <= '0;
      ocol_r      <= '0;
      orow_r      <= '0;
      oring_r     <= '0;
      items_r     <= '0;
      results_r   <= '0;
      dx_r        <= '0;
      dy_r        <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      ring_r      <= ring_nxt;
      ocol_r      <= ocol_nxt;
      orow_r      <= orow_nxt;
      oring_r     <= oring_nxt;
      items_r     <= items_nxt;
      results_r   <= results_nxt;
      dx_r        <= dx_nxt;
      dy_r        <= dy_nxt;
      rd_valid_r  <= ram_req.re;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pix_r      <= pix_nxt;
    best_r     <= best_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_value = out_val_r;
  assign out_ch.last_of_frame  = out_last_r;

  `DCWF_ASSERT_IMP(a_no_rw_overlap, ram_req.we, !ram_req.re, "line store read and write together")
  `DCWF_ASSERT_NEXT(a_tail_to_emit, state_r == ST_TAIL && !cfg_hit, state_r == ST_EMIT, "sweep tail did not emit")
  `DCWF_ASSERT_IMP(a_results_bound, !$past(cfg_hit), results_r < total_r, "result count passed frame size")
endmodule
`default_nettype wire

>>> rtl/dark_channel_window_filter_unit.sv
// Dark channel window filter: per-pixel channel minimum, then a square window
// minimum or maximum with mirrored edges. Top level; depends on dcwf_pkg,
// dcwf_if, dcwf_line_ram and dcwf_window_ctrl.
//
// Usage. Pixels arrive in raster order on in_ch, one beat per pixel; command 1
// marks a drain beat that pushes out the tail of the frame. Each beat gives at
// most one result on out_ch; the result for a frame position leaves on the
// beat radius*width+radius beats later, and last_of_frame marks the final one.
// Register writes on cfg_ch (index 0 width, 1 height, 2 radius, 3 mode) are
// always ready and restart the frame; write them only while the block is idle.
// Flow: a beat that gives no result passes through ST_STEP back to ST_IDLE,
// where the next beat is taken. A beat that yields a result sweeps the (2r+1)^2
// window through the single read port of the line store, one entry per cycle,
// in ST_SCAN, then passes ST_TAIL to ST_EMIT, which loads the output register;
// no new beat is taken until that beat is done.
// The result sits in an output register; a stalled receiver holds it, and the
// block still takes the next beat, waiting only when a new result is ready.
// Reset (rst_n low, synchronous) restores the register defaults and clears
// all counters; the line store itself is not cleared and needs no sweep.
`default_nettype none
module dark_channel_window_filter_unit (
  input wire logic   clk,
  input wire logic   rst_n,
  dcwf_in_if.sink    in_ch,
  dcwf_out_if.source out_ch,
  dcwf_cfg_if.sink   cfg_ch
);
  dcwf_pkg::ram_req_t ram_req;
  dcwf_pkg::pix_t     ram_rdata;

  dcwf_window_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  dcwf_line_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );
endmodule
`default_nettype wire

>>> dv/dark_channel_window_filter_unit_chk.sv
// Checker for the dark channel window filter: watches the pixel, result and
// register channels, predicts each result and compares. Depends on dcwf_pkg, dcwf_if.
module dark_channel_window_filter_unit_chk (
  input  logic clk,
  input  logic rst_n,
  dcwf_in_if   in_ch,
  dcwf_out_if  out_ch,
  dcwf_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    dcwf_pkg::pix_t value;
    logic           last;
  } dark_res_t;

  dark_res_t      dark_q[$];
  dcwf_pkg::pix_t plane_rows [0:dcwf_pkg::Depth-1];
  logic [10:0]    width_reg;
  logic [12:0]    height_reg;
  logic [2:0]     radius_reg;
  logic           max_mode;
  int             col_pos, row_pos, beats_in, results_out;

  assign pending = dark_q.size();

  function automatic int fold_edge(int pos, int off, int n);
    int v;
    v = pos + off;
    if (v < 0) v = -v;
    if (v > n - 1) v = 2 * (n - 1) - v;
    if (v < 0) v = 0;
    return v;
  endfunction

  function automatic dcwf_pkg::pix_t window_extreme(int p, int w, int h, int r);
    dcwf_pkg::pix_t best, v;
    int py, px, y, x;
    py = p / w;
    px = p % w;
    best = max_mode ? 8'd0 : 8'd255;
    for (int dy = -r; dy <= r; dy++) begin
      y = fold_edge(py, dy, h) % dcwf_pkg::RingRows;
      for (int dx = -r; dx <= r; dx++) begin
        x = fold_edge(px, dx, w);
        v = plane_rows[y * dcwf_pkg::MaxWidth + x];
        if (max_mode ? (v > best) : (v < best)) best = v;
      end
    end
    return best;
  endfunction

  task automatic predict_beat();
    int w, h, r, total, lag;
    dcwf_pkg::pix_t m;
    dark_res_t res;
    w = (width_reg < 2) ? 2 : (width_reg > dcwf_pkg::MaxWidth) ? dcwf_pkg::MaxWidth : width_reg;
    h = (height_reg < 2) ? 2 : (height_reg > dcwf_pkg::MaxHeight) ? dcwf_pkg::MaxHeight
      : height_reg;
    r = radius_reg;
    if (r > dcwf_pkg::MaxRadius) r = dcwf_pkg::MaxRadius;
    if (r > w - 1) r = w - 1;
    if (r > h - 1) r = h - 1;
    total = w * h;
    lag = r * w + r;
    if (beats_in < total) begin
      // A drain beat before the frame is complete is simply ignored.
      if (in_ch.command) return;
      m = in_ch.pixel_red < in_ch.pixel_green ? in_ch.pixel_red : in_ch.pixel_green;
      if (in_ch.pixel_blue < m) m = in_ch.pixel_blue;
      plane_rows[(row_pos % dcwf_pkg::RingRows) * dcwf_pkg::MaxWidth + col_pos] = m;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
    end
    beats_in++;
    if (beats_in - results_out > lag && results_out < total) begin
      res.value = window_extreme(results_out, w, h, r);
      results_out++;
      res.last = results_out >= total;
      dark_q.insert(dark_q.size(), res);
      if (res.last) begin
        col_pos = 0; row_pos = 0; beats_in = 0; results_out = 0;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    foreach (plane_rows[i]) plane_rows[i] = '0;
  end

  always @(posedge clk) begin
    dark_res_t exp_res;
    if (!rst_n) begin
      width_reg = 11'd1024; height_reg = 13'd768; radius_reg = 3'd1; max_mode = 1'b0;
      col_pos = 0; row_pos = 0; beats_in = 0; results_out = 0;
      dark_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index <= dcwf_pkg::CFG_MODE) begin
        case (dcwf_pkg::cfg_idx_t'(cfg_ch.index))
          dcwf_pkg::CFG_WIDTH:  width_reg = cfg_ch.data[10:0];
          dcwf_pkg::CFG_HEIGHT: height_reg = cfg_ch.data;
          dcwf_pkg::CFG_RADIUS: radius_reg = cfg_ch.data[2:0];
          default:              max_mode = cfg_ch.data[0];
        endcase
        col_pos = 0; row_pos = 0; beats_in = 0; results_out = 0;
        dark_q.delete();
      end
      if (in_ch.valid && in_ch.ready) predict_beat();
      if (out_ch.valid && out_ch.ready) begin
        if (dark_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat value %0d last %0b", $realtime,
                   out_ch.filtered_value, out_ch.last_of_frame);
        end else begin
          exp_res = dark_q.pop_front();
          if (out_ch.filtered_value !== exp_res.value) begin
            fail_count++;
            $display("%0t: filtered_value expected %0d actual %0d", $realtime,
                     exp_res.value, out_ch.filtered_value);
          end
          if (out_ch.last_of_frame !== exp_res.last) begin
            fail_count++;
            $display("%0t: last_of_frame expected %0b actual %0b", $realtime,
                     exp_res.last, out_ch.last_of_frame);
          end
        end
      end
    end
  end
endmodule

>>> dv/dark_channel_window_filter_unit_tb.sv
// Top of the dark channel window filter testbench: clock, reset, pixel and
// register stimulus, receiver stalls and verdict. Depends on dcwf_pkg, dcwf_if, the checker.
module dark_channel_window_filter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending;
  int   send_idle = 0, recv_idle = 0;
  int   beats_sent = 0;
  int   quiet_cycles = 0;
  int   fw, fh, fr;

  dcwf_in_if  in_ch();
  dcwf_out_if out_ch();
  dcwf_cfg_if cfg_ch();

  dark_channel_window_filter_unit u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  dark_channel_window_filter_unit_chk u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0; in_ch.command = 1'b0;
    in_ch.pixel_blue = '0; in_ch.pixel_green = '0; in_ch.pixel_red = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  always @(negedge clk) out_ch.ready = ($urandom_range(0, 99) >= recv_idle);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("dark_channel_window_filter_unit_tb: FAIL");
      $finish;
    end
  end

  // All tasks start and end just after a falling edge.
  task automatic write_reg(input logic [2:0] idx, input logic [12:0] value);
    cfg_ch.valid = 1'b1; cfg_ch.index = idx; cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic send_beat(input logic cmd, input logic [7:0] b, g, r);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1; in_ch.command = cmd;
    in_ch.pixel_blue = b; in_ch.pixel_green = g; in_ch.pixel_red = r;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    beats_sent++;
    if (beats_sent == 700) begin send_idle = 59; recv_idle = 29; end
    if (beats_sent == 1400) begin send_idle = 0; recv_idle = 0; end
  endtask

  task automatic await_idle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_frame(input logic [10:0] w, input logic [12:0] h,
                           input logic [2:0] r, input logic mode);
    await_idle();
    write_reg(dcwf_pkg::CFG_WIDTH, 13'(w));
    write_reg(dcwf_pkg::CFG_HEIGHT, h);
    write_reg(dcwf_pkg::CFG_RADIUS, 13'(r));
    write_reg(dcwf_pkg::CFG_MODE, 13'(mode));
    fw = (w < 2) ? 2 : (w > dcwf_pkg::MaxWidth) ? dcwf_pkg::MaxWidth : w;
    fh = (h < 2) ? 2 : (h > dcwf_pkg::MaxHeight) ? dcwf_pkg::MaxHeight : h;
    fr = r;
    if (fr > fw - 1) fr = fw - 1;
    if (fr > fh - 1) fr = fh - 1;
  endtask

  // Pixels with stray drains mixed in, then a tail of drains and discarded pixels.
  task automatic run_frame(input int drain_pct);
    for (int i = 0; i < fw * fh; i++) begin
      if ($urandom_range(0, 99) < drain_pct)
        send_beat(1'b1, 8'($urandom), 8'($urandom), 8'($urandom));
      send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    for (int i = 0; i < fr * fw + fr; i++)
      send_beat($urandom_range(0, 3) != 0, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  initial begin
    send_idle = 29; recv_idle = 59;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: channel extremes, each channel the least, drains while pixels are due.
    set_frame(11'd4, 13'd3, 3'd1, 1'b0);
    send_beat(1'b1, 8'd0, 8'd0, 8'd0);
    send_beat(1'b0, 8'd255, 8'd255, 8'd255);
    send_beat(1'b0, 8'd0, 8'd0, 8'd0);
    send_beat(1'b0, 8'd10, 8'd200, 8'd100);
    send_beat(1'b0, 8'd200, 8'd10, 8'd100);
    send_beat(1'b1, 8'd255, 8'd255, 8'd255);
    send_beat(1'b0, 8'd200, 8'd100, 8'd10);
    send_beat(1'b0, 8'd255, 8'd0, 8'd255);
    for (int i = 0; i < 6; i++) send_beat(1'b0, 8'hAA, 8'h55, 8'hFF);
    send_beat(1'b0, 8'd7, 8'd7, 8'd7);
    for (int i = 0; i < 4; i++) send_beat(i[0], 8'd9, 8'd9, 8'd9);
    // Writes beyond the register list change nothing; the frame runs on.
    await_idle();
    write_reg(3'd4, 13'h1FFF);
    write_reg(3'd7, 13'h0000);
    set_frame(11'd5, 13'd4, 3'd2, 1'b1);
    run_frame(10);

    // Register extremes and saturation.
    set_frame(11'd0, 13'd0, 3'd7, 1'b1);
    run_frame(20);
    // Saturated width: only the opening of the frame, far enough for results to leave.
    set_frame(11'd2047, 13'd2, 3'd1, 1'b0);
    for (int i = 0; i < 1040; i++) send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    set_frame(11'd16, 13'd16, 3'd7, 1'b0);
    run_frame(5);
    // A partial frame left with nothing due, then abandoned by a write.
    set_frame(11'd12, 13'd9, 3'd3, 1'b1);
    for (int i = 0; i < 20; i++) send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    // Saturated height, again only the opening of the frame.
    set_frame(11'd3, 13'd8191, 3'd1, 1'b0);
    for (int i = 0; i < 40; i++) send_beat(1'b0, 8'($urandom), 8'($urandom), 8'($urandom));

    while (beats_sent < 1800) begin
      set_frame(11'($urandom_range(2, 12)), 13'($urandom_range(2, 10)),
                3'($urandom_range(0, 7)), 1'($urandom));
      run_frame($urandom_range(0, 15));
    end

    await_idle();
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("dark_channel_window_filter_unit_tb: PASS");
    else
      $display("dark_channel_window_filter_unit_tb: FAIL");
    $finish;
  end
endmodule

>>> files.f
+incdir+rtl
rtl/dcwf_pkg.sv
rtl/dcwf_if.sv
rtl/dcwf_line_ram.sv
rtl/dcwf_window_ctrl.sv
rtl/dark_channel_window_filter_unit.sv
dv/dark_channel_window_filter_unit_chk.sv
dv/dark_channel_window_filter_unit_tb.sv
